### design/mlut_pkg.sv
// Shared codes, constants and types for the multi-lane serial transmitter.
package mlut_pkg;

    localparam int LANES_DEF     = 8;
    localparam int DATA_BITS_DEF = 8;

    // Item kinds
    localparam logic [1:0] KIND_TICK       = 2'd0;
    localparam logic [1:0] KIND_SEND_BYTE  = 2'd1;
    localparam logic [1:0] KIND_SEND_LANES = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOT_CFG = 2'd1;
    localparam logic [1:0] ST_BUSY    = 2'd2;

    // Configuration register indexes
    localparam logic REG_BIT_PERIOD = 1'b0;
    localparam logic REG_LANE_MASK  = 1'b1;

    localparam logic [7:0] LANE_MASK_RST = 8'h01;

    typedef struct packed {
        logic [7:0] line_levels;
        logic       busy_res;
        logic [1:0] status;
    } out_item_t;

endpackage

### design/multi_lane_uart_transmitter_core.sv
// Multi-lane 8N1 serial frame transmitter core.
//
// Input channel (in_valid/in_ready): one beat is a tick, a single-byte send or
// a lane-pattern send. Each tick advances the running frame by one timing
// unit; a bit lasts bit_period ticks. Sends while unconfigured (bit_period of
// zero) or while a frame runs are rejected with a status code.
// Output channel (out_valid/out_ready): exactly one result beat per input beat
// with the line levels after that beat, the busy flag and the status.
// Config channel (cfg_valid/cfg_ready): always ready; index 0 is bit_period,
// index 1 is lane_mask. Write only while the core is idle.
// Throughput: one beat per cycle while in_ready is high. Latency: from an empty
// queue, the result is visible the cycle after the input beat. The frame update
// and the result are formed in one pass between the state registers and a
// two-entry output queue. Receiver stall: the queue holds two results; in_ready
// drops only when both entries are full and rises again once one is taken.
// Reset: all lines idle high, no frame running, bit_period 0, lane_mask 1.
module multi_lane_uart_transmitter_core #(
    parameter int LANES     = mlut_pkg::LANES_DEF,
    parameter int DATA_BITS = mlut_pkg::DATA_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  kind,
    input  logic [7:0]  byte_value,
    input  logic [63:0] lane_patterns,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  line_levels,
    output logic        busy_res,
    output logic [1:0]  status,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int         FRAME_W    = DATA_BITS * 8;
    localparam logic [3:0] LAST_DATA  = 4'(DATA_BITS);
    localparam logic [3:0] STOP_PHASE = 4'(DATA_BITS + 1);
    localparam logic [7:0] LANE_LIMIT = 8'((1 << LANES) - 1);

    logic [15:0]        bit_period_reg;
    logic [7:0]         lane_mask_reg;

    logic [3:0]         bit_phase_reg,  bit_phase_next;
    logic [15:0]        tick_count_reg, tick_count_next;
    logic [FRAME_W-1:0] frame_data_reg, frame_data_next;
    logic               lane_mode_reg,  lane_mode_next;
    logic [7:0]         line_state_reg, line_state_next;
    logic               active_reg,     active_next;

    logic               in_accept;
    logic [1:0]         status_c;
    logic [16:0]        tick_inc;
    logic [3:0]         phase_inc;
    mlut_pkg::out_item_t item_c;

    mlut_pkg::out_item_t q_mem [2];
    logic               wr_ptr_reg;
    logic               rd_ptr_reg;
    logic [1:0]         count_reg;
    logic               out_accept;

    function automatic logic [7:0] phase_pattern(
        input logic [3:0]         phase,
        input logic               lane_mode,
        input logic [FRAME_W-1:0] data
    );
        logic [2:0] idx;
        logic [7:0] pat;
        idx = 3'(phase - 4'd1);
        if (phase == 4'd0) begin
            pat = 8'h00;
        end else if (phase > LAST_DATA) begin
            pat = 8'hFF;
        end else if (lane_mode) begin
            pat = data[{idx, 3'b000} +: 8];
        end else begin
            pat = {8{data[idx]}};
        end
        return pat;
    endfunction

    assign cfg_ready = 1'b1;
    assign in_ready  = (count_reg != 2'd2);
    assign in_accept = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            bit_period_reg <= '0;
            lane_mask_reg  <= mlut_pkg::LANE_MASK_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                mlut_pkg::REG_BIT_PERIOD: bit_period_reg <= cfg_data;
                mlut_pkg::REG_LANE_MASK:  lane_mask_reg  <= cfg_data[7:0];
                default:                  bit_period_reg <= bit_period_reg;
            endcase
        end
    end

    assign tick_inc  = {1'b0, tick_count_reg} + 17'd1;
    assign phase_inc = bit_phase_reg + 4'd1;

    always_comb begin
        bit_phase_next  = bit_phase_reg;
        tick_count_next = tick_count_reg;
        frame_data_next = frame_data_reg;
        lane_mode_next  = lane_mode_reg;
        line_state_next = line_state_reg;
        active_next     = active_reg;
        status_c        = mlut_pkg::ST_OK;
        if (in_accept) begin
            case (kind)
                mlut_pkg::KIND_TICK: begin
                    if (active_reg) begin
                        if (tick_inc >= {1'b0, bit_period_reg}) begin
                            tick_count_next = '0;
                            if (phase_inc > STOP_PHASE) begin
                                active_next     = 1'b0;
                                bit_phase_next  = '0;
                                line_state_next = 8'hFF;
                            end else begin
                                bit_phase_next  = phase_inc;
                                line_state_next = phase_pattern(phase_inc, lane_mode_reg,
                                                                frame_data_reg);
                            end
                        end else begin
                            tick_count_next = tick_inc[15:0];
                        end
                    end
                end
                mlut_pkg::KIND_SEND_BYTE, mlut_pkg::KIND_SEND_LANES: begin
                    if (bit_period_reg == 16'd0) begin
                        status_c = mlut_pkg::ST_NOT_CFG;
                    end else if (active_reg) begin
                        status_c = mlut_pkg::ST_BUSY;
                    end else begin
                        lane_mode_next  = (kind == mlut_pkg::KIND_SEND_LANES);
                        frame_data_next = (kind == mlut_pkg::KIND_SEND_LANES)
                                        ? lane_patterns[FRAME_W-1:0]
                                        : FRAME_W'(byte_value);
                        active_next     = 1'b1;
                        bit_phase_next  = '0;
                        tick_count_next = '0;
                        line_state_next = 8'h00;   // start bit
                    end
                end
                default: begin
                    status_c = mlut_pkg::ST_OK;
                end
            endcase
        end
    end

    always_comb begin
        item_c.line_levels = line_state_next | ~(lane_mask_reg & LANE_LIMIT);
        item_c.busy_res    = active_next;
        item_c.status      = status_c;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            bit_phase_reg  <= '0;
            tick_count_reg <= '0;
            frame_data_reg <= '0;
            lane_mode_reg  <= 1'b0;
            line_state_reg <= 8'hFF;
            active_reg     <= 1'b0;
        end else begin
            bit_phase_reg  <= bit_phase_next;
            tick_count_reg <= tick_count_next;
            frame_data_reg <= frame_data_next;
            lane_mode_reg  <= lane_mode_next;
            line_state_reg <= line_state_next;
            active_reg     <= active_next;
        end
    end

    // Two-entry result queue
    assign out_valid  = (count_reg != 2'd0);
    assign out_accept = out_valid && out_ready;

    always_ff @(posedge clk) begin
        if (in_accept) begin
            q_mem[wr_ptr_reg] <= item_c;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            if (in_accept) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (out_accept) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            case ({in_accept, out_accept})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    assign line_levels = q_mem[rd_ptr_reg].line_levels;
    assign busy_res    = q_mem[rd_ptr_reg].busy_res;
    assign status      = q_mem[rd_ptr_reg].status;

    a_idle_phase : assert property (@(posedge clk) disable iff (!rst_n)
        !active_reg |-> (bit_phase_reg == 4'd0 && line_state_reg == 8'hFF))
        else $error("idle with frame phase or line pattern left over");

    a_phase_range : assert property (@(posedge clk) disable iff (!rst_n)
        bit_phase_reg <= STOP_PHASE)
        else $error("bit phase beyond stop bit");

    a_queue_bound : assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg <= 2'd2) && (count_reg != 2'd2 || !in_ready))
        else $error("result queue overrun");

    a_send_starts : assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (kind == mlut_pkg::KIND_SEND_BYTE || kind == mlut_pkg::KIND_SEND_LANES)
         && status_c == mlut_pkg::ST_OK)
        |=> (active_reg && bit_phase_reg == 4'd0 && tick_count_reg == 16'd0))
        else $error("accepted send did not start a frame");

    a_tick_hold : assert property (@(posedge clk) disable iff (!rst_n)
        !in_accept |=> ($stable(bit_phase_reg) && $stable(tick_count_reg)
                        && $stable(active_reg)))
        else $error("frame state moved without a beat");

endmodule

### tb/tb.sv
// Self-checking testbench for the multi-lane serial frame transmitter core.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int LANES = mlut_pkg::LANES_DEF;
    localparam int DATA_BITS = mlut_pkg::DATA_BITS_DEF;
    localparam logic [7:0] LANE_LIMIT = 8'((9'd1 << LANES) - 9'd1);
    localparam int STALL_LIMIT = 5000;
    localparam int RANDOM_ITEMS = 700;

    // Predicts the line levels, busy flag and status of every beat and checks the result beats in order.
    class frame_scoreboard;
        mlut_pkg::out_item_t expected_q[$];
        logic [15:0] period;
        logic [7:0]  mask;
        logic [3:0]  phase;
        logic [15:0] ticks;
        logic [63:0] data;
        logic        lane_mode;
        logic [7:0]  line_st;
        logic        active;
        int          errors;
        int          checked;
        int          frames;
        int          rejects;
        int          settings;

        function new();
            period    = 16'd0;
            mask      = mlut_pkg::LANE_MASK_RST;
            phase     = 4'd0;
            ticks     = 16'd0;
            data      = 64'd0;
            lane_mode = 1'b0;
            line_st   = 8'hFF;
            active    = 1'b0;
            errors    = 0;
            checked   = 0;
            frames    = 0;
            rejects   = 0;
            settings  = 0;
        endfunction

        function logic busy();
            return active;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void write_reg(logic idx, logic [15:0] val);
            if (idx == mlut_pkg::REG_BIT_PERIOD)
                period = val;
            else
                mask = val[7:0];
            settings++;
        endfunction

        // Line pattern of a bit time: start low, stop high, data from the frame.
        function logic [7:0] bit_pattern(logic [3:0] ph);
            logic [2:0] idx;
            if (ph == 4'd0)
                return 8'h00;
            if (ph > DATA_BITS)
                return 8'hFF;
            idx = 3'(ph - 4'd1);
            if (lane_mode)
                return data[8*idx +: 8];
            return data[idx] ? 8'hFF : 8'h00;
        endfunction

        function void note_input(logic [1:0] k, logic [7:0] b, logic [63:0] l);
            mlut_pkg::out_item_t exp_item;
            logic [16:0]         next_count;
            exp_item.status = mlut_pkg::ST_OK;
            if (k == mlut_pkg::KIND_TICK)
            begin
                if (active)
                begin
                    next_count = ticks + 17'd1;
                    // a period of zero still ends the bit after one tick
                    if (next_count >= {1'b0, period})
                    begin
                        ticks = 16'd0;
                        phase = phase + 4'd1;
                        if (phase >= DATA_BITS + 2)
                        begin
                            active  = 1'b0;
                            phase   = 4'd0;
                            line_st = 8'hFF;
                        end
                        else
                        begin
                            line_st = bit_pattern(phase);
                        end
                    end
                    else
                    begin
                        ticks = next_count[15:0];
                    end
                end
            end
            else if (k == mlut_pkg::KIND_SEND_BYTE || k == mlut_pkg::KIND_SEND_LANES)
            begin
                // not-configured takes priority over busy
                if (period == 16'd0)
                begin
                    exp_item.status = mlut_pkg::ST_NOT_CFG;
                    rejects++;
                end
                else if (active)
                begin
                    exp_item.status = mlut_pkg::ST_BUSY;
                    rejects++;
                end
                else
                begin
                    lane_mode = (k == mlut_pkg::KIND_SEND_LANES);
                    data      = lane_mode ? l : {56'd0, b};
                    active    = 1'b1;
                    phase     = 4'd0;
                    ticks     = 16'd0;
                    line_st   = bit_pattern(4'd0);
                    frames++;
                end
            end
            exp_item.line_levels = line_st | ~(mask & LANE_LIMIT);
            exp_item.busy_res    = active;
            expected_q.push_back(exp_item);
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(mlut_pkg::out_item_t got);
            mlut_pkg::out_item_t want;
            if (expected_q.size() == 0)
            begin
                report($sformatf("result beat with nothing outstanding (levels %02h)",
                                 got.line_levels));
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (got.line_levels !== want.line_levels)
                report($sformatf("beat %0d line_levels %02h, want %02h",
                                 checked, got.line_levels, want.line_levels));
            if (got.busy_res !== want.busy_res)
                report($sformatf("beat %0d busy_res %b, want %b",
                                 checked, got.busy_res, want.busy_res));
            if (got.status !== want.status)
                report($sformatf("beat %0d status %0d, want %0d",
                                 checked, got.status, want.status));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  kind;
    logic [7:0]  byte_value;
    logic [63:0] lane_patterns;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  line_levels;
    logic        busy_res;
    logic [1:0]  status;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [15:0] cfg_data;

    frame_scoreboard     sb;
    logic                steady;
    int                  counted;
    int                  quiet;
    mlut_pkg::out_item_t seen;

    multi_lane_uart_transmitter_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .kind          (kind),
        .byte_value    (byte_value),
        .lane_patterns (lane_patterns),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .line_levels   (line_levels),
        .busy_res      (busy_res),
        .status        (status),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
        clk = 1'b0;

    always #5 clk = ~clk;

    // Result side: check each accepted beat, then choose the next ready level.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                seen = {line_levels, busy_res, status};
                sb.check_result(seen);
            end
            out_ready <= steady || ($urandom_range(99) >= 29);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            begin
                quiet <= 0;
            end
            else if (quiet >= STALL_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
            else
            begin
                quiet <= quiet + 1;
            end
        end
    end

    // One input beat; valid stays high from the previous beat unless idle cycles are taken.
    task automatic send_item(logic [1:0] k, logic [7:0] b, logic [63:0] l);
        while (!steady && $urandom_range(99) < 29)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        kind          <= k;
        byte_value    <= b;
        lane_patterns <= l;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_input(k, b, l);
        if (k != KIND_UNUSED)
            counted++;
    endtask

    task automatic send_ticks(int n);
        repeat (n) send_item(mlut_pkg::KIND_TICK, 8'($urandom), {$urandom, $urandom});
    endtask

    // Drain every outstanding result before touching the registers.
    task automatic settle(int extra);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic configure(logic [15:0] per, logic [7:0] msk);
        cfg_valid <= 1'b1;
        cfg_index <= mlut_pkg::REG_BIT_PERIOD;
        cfg_data  <= per;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.write_reg(mlut_pkg::REG_BIT_PERIOD, per);
        cfg_index <= mlut_pkg::REG_LANE_MASK;
        cfg_data  <= {8'($urandom), msk};
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.write_reg(mlut_pkg::REG_LANE_MASK, {8'd0, msk});
        cfg_valid <= 1'b0;
    endtask

    // Mostly complete frames with random content, plus rejected and unused beats.
    task automatic run_phase(int n_items);
        int          pick;
        logic [1:0]  k;
        logic [7:0]  b;
        logic [63:0] l;
        repeat (n_items)
        begin
            b = 8'($urandom);
            l = {$urandom, $urandom};
            if ($urandom_range(15) == 0)
                l = {64{l[0]}};
            pick = $urandom_range(99);
            if (!sb.busy())
                k = (pick < 45) ? mlut_pkg::KIND_SEND_BYTE :
                    (pick < 85) ? mlut_pkg::KIND_SEND_LANES :
                    (pick < 95) ? mlut_pkg::KIND_TICK : KIND_UNUSED;
            else
                k = (pick < 88) ? mlut_pkg::KIND_TICK :
                    (pick < 92) ? mlut_pkg::KIND_SEND_BYTE :
                    (pick < 96) ? mlut_pkg::KIND_SEND_LANES : KIND_UNUSED;
            send_item(k, b, l);
        end
    endtask

    initial
    begin
        int          pick;
        int          phase_no;
        logic [15:0] per;
        logic [7:0]  msk;

        sb = new();
        steady        = 1'b0;
        counted       = 0;
        quiet         = 0;
        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        kind          <= mlut_pkg::KIND_TICK;
        byte_value    <= 8'd0;
        lane_patterns <= 64'd0;
        out_ready     <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_index     <= mlut_pkg::REG_BIT_PERIOD;
        cfg_data      <= 16'd0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // unconfigured: both sends rejected, tick and unused kind are harmless
        send_item(mlut_pkg::KIND_SEND_BYTE, 8'hFF, 64'd0);
        send_item(mlut_pkg::KIND_SEND_LANES, 8'h00, {64{1'b1}});
        send_item(mlut_pkg::KIND_TICK, 8'h00, 64'd0);
        send_item(KIND_UNUSED, 8'hFF, {64{1'b1}});
        settle(3);
        configure(16'd1, 8'hFF);
        send_item(mlut_pkg::KIND_SEND_BYTE, 8'hA5, 64'd0);
        send_item(mlut_pkg::KIND_SEND_LANES, 8'h00, 64'h0123_4567_89AB_CDEF);
        send_item(KIND_UNUSED, 8'h00, 64'd0);
        send_ticks(5);
        // period and mask change while the frame runs
        settle(3);
        configure(16'd3, 8'h0F);
        send_ticks(5);
        settle(3);
        configure(16'd0, 8'h00);
        send_ticks(5);
        send_item(mlut_pkg::KIND_SEND_BYTE, 8'h00, 64'd0);

        phase_no = 0;
        while (counted < RANDOM_ITEMS)
        begin
            settle(3);
            pick = $urandom_range(99);
            if (pick < 5)
                per = 16'd0;
            else if (pick < 10)
                per = 16'hFFFF;
            else if (pick < 80)
                per = 16'($urandom_range(1, 4));
            else
                per = 16'($urandom_range(5, 16));
            pick = $urandom_range(99);
            msk = (pick < 10) ? 8'h00 : (pick < 20) ? 8'hFF : 8'($urandom);
            configure(per, msk);
            steady = (phase_no >= 6 && phase_no < 10);
            run_phase($urandom_range(20, 70));
            phase_no++;
        end
        steady = 1'b0;
        settle(10);

        $display("Checked %0d result beats: %0d frames started, %0d sends rejected,",
                 sb.checked, sb.frames, sb.rejects);
        $display("over %0d register writes with mid-frame period and mask changes.",
                 sb.settings);
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

### sim.f
design/mlut_pkg.sv
design/multi_lane_uart_transmitter_core.sv
tb/tb.sv
